// ===== sv/prc_pkg.sv =====
// Shared types and constants of the packet rule classifier.
// Item and result structs, the stored rule layout and the controller/datapath
// command and status structs. No dependencies.
package prc_pkg;

	localparam logic KIND_LOAD     = 1'b0;
	localparam logic KIND_CLASSIFY = 1'b1;

	localparam logic [7:0] PROTO_TCP = 8'd6;
	localparam logic [7:0] PROTO_UDP = 8'd17;

	localparam int WILD_PROTO = 0;
	localparam int WILD_DIR   = 1;
	localparam int WILD_SADDR = 2;
	localparam int WILD_DADDR = 3;
	localparam int WILD_SPORT = 4;
	localparam int WILD_DPORT = 5;

	localparam logic REG_FILTER_ENABLE = 1'b0;
	localparam logic REG_GROUP_MASK    = 1'b1;

	localparam int PADDR_W = 3;

	typedef struct packed {
		logic        kind;
		logic [4:0]  slot;
		logic [3:0]  rule_group;
		logic        drop_action;
		logic [7:0]  protocol;
		logic        direction;
		logic [5:0]  wild_flags;
		logic [31:0] src_addr;
		logic [31:0] dst_addr;
		logic [15:0] sport;
		logic [15:0] dst_port;
	} in_item_t;

	typedef struct packed {
		logic       drop;
		logic [4:0] hit_slot;
		logic [3:0] hit_group;
	} out_item_t;

	typedef struct packed {
		logic        drop_action;
		logic [3:0]  rule_group;
		logic [5:0]  wild_flags;
		logic        direction;
		logic [7:0]  protocol;
		logic [31:0] src_addr;
		logic [31:0] dst_addr;
		logic [15:0] sport;
		logic [15:0] dst_port;
	} rule_t;

	typedef struct packed {
		logic write;
		logic capture;
		logic step;
		logic load_out;
	} cmd_t;

	typedef struct packed {
		logic last;
	} status_t;

endpackage

// ===== sv/packet_rule_classifier.sv =====
// A classify item runs through the scan, drain and finish states before its result is
// registered, and no new item is taken until then. The scan reads one rule slot per cycle
// from the single read port of the rule memory.
// A load item writes its rule slot, if the slot is below RULE_SLOTS, and gives no result.
// Reset clears control state, the configuration registers and every slot's valid bit,
// so all slots read as allow rules; no clearing pass is needed.
module packet_rule_classifier #(
	parameter int RULE_SLOTS = 32,
	parameter int NUM_GROUPS = 8
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         item_valid,
	output logic                         item_stall,
	input  prc_pkg::in_item_t            item,
	output logic                         result_valid,
	input  logic                         result_stall,
	output prc_pkg::out_item_t           result,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [prc_pkg::PADDR_W-1:0]  paddr,
	input  logic [31:0]                  pwdata,
	output logic [31:0]                  prdata,
	output logic                         pready
);
	import prc_pkg::*;

	cmd_t       cmd;
	status_t    status;
	logic       filter_enable_q;
	logic [7:0] group_mask_q;
	logic       reg_wr;
	logic       reg_idx;

	assign pready  = 1'b1;
	assign reg_wr  = psel && penable && pwrite && pready;
	assign reg_idx = paddr[2];

	always_comb begin
		unique case (reg_idx)
			REG_FILTER_ENABLE: prdata = {31'b0, filter_enable_q};
			REG_GROUP_MASK:    prdata = {24'b0, group_mask_q};
			default:           prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			filter_enable_q <= 1'b0;
			group_mask_q    <= '0;
		end else if (reg_wr) begin
			if (reg_idx == REG_FILTER_ENABLE) begin
				filter_enable_q <= pwdata[0];
			end else begin
				group_mask_q <= pwdata[7:0];
			end
		end
	end

	prc_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_kind    (item.kind),
		.item_stall   (item_stall),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.status       (status),
		.cmd          (cmd)
	);

	prc_datapath #(
		.RULE_SLOTS (RULE_SLOTS),
		.NUM_GROUPS (NUM_GROUPS)
	) u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.status        (status),
		.item          (item),
		.filter_enable (filter_enable_q),
		.group_mask    (group_mask_q),
		.result        (result)
	);

`ifndef ASSERT_OFF
	a_busy_after_classify: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && !item_stall && (item.kind == KIND_CLASSIFY) |=> item_stall)
		else $error("classifier accepted an item during a scan");

	a_no_drop_clean: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result.drop |-> (result.hit_slot == 5'd0) && (result.hit_group == 4'd0))
		else $error("accept result carries a rule hit");

	a_group_range: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (result.hit_group <= 4'(NUM_GROUPS)))
		else $error("result names a group beyond the configured count");
`endif

endmodule

// ===== sv/prc_ctrl.sv =====
// Controller of the packet rule classifier: accepts items, sequences the
// rule scan and owns the result valid flag. Depends on prc_pkg.
module prc_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             item_valid,
	input  logic             item_kind,
	output logic             item_stall,
	output logic             result_valid,
	input  logic             result_stall,
	input  prc_pkg::status_t status,
	output prc_pkg::cmd_t    cmd
);
	import prc_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_FINISH
	} state_t;

	state_t state_q;
	logic   result_valid_q;
	logic   accept;

	assign item_stall   = (state_q != ST_IDLE);
	assign result_valid = result_valid_q;
	assign accept       = (state_q == ST_IDLE) && item_valid;

	always_comb begin
		cmd.write    = accept && (item_kind == KIND_LOAD);
		cmd.capture  = accept && (item_kind == KIND_CLASSIFY);
		cmd.step     = (state_q == ST_SCAN);
		cmd.load_out = (state_q == ST_FINISH) && (!result_valid_q || !result_stall);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			result_valid_q <= 1'b0;
		end else begin
			if (cmd.load_out) begin
				result_valid_q <= 1'b1;
			end else if (!result_stall) begin
				result_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (cmd.capture) begin
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (status.last) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					state_q <= ST_FINISH;
				end
				ST_FINISH: begin
					if (cmd.load_out) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

// ===== sv/prc_datapath.sv =====
// Datapath of the packet rule classifier: rule memory with per-slot valid
// bits, scan address counter, rule compare and best-match tracking, result
// register. Depends on prc_pkg.
module prc_datapath #(
	parameter int RULE_SLOTS = 32,
	parameter int NUM_GROUPS = 8
) (
	input  logic               clk,
	input  logic               arst_n,
	input  prc_pkg::cmd_t      cmd,
	output prc_pkg::status_t   status,
	input  prc_pkg::in_item_t  item,
	input  logic               filter_enable,
	input  logic [7:0]         group_mask,
	output prc_pkg::out_item_t result
);
	import prc_pkg::*;

	localparam int SLOT_W = (RULE_SLOTS > 1) ? $clog2(RULE_SLOTS) : 1;

	rule_t                  rule_mem [RULE_SLOTS];
	logic [RULE_SLOTS-1:0]  valid_q;
	in_item_t               pkt_q;
	logic [SLOT_W-1:0]      addr_q;
	logic [SLOT_W-1:0]      wr_idx;
	logic                   wr_ok;
	rule_t                  rule_s1;
	logic                   vld_s1;
	logic [SLOT_W-1:0]      slot_s1;
	logic                   best_hit_q;
	logic [SLOT_W-1:0]      best_slot_q;
	logic [3:0]             best_grp_q;
	out_item_t              result_q;
	logic                   proto_ok;
	logic                   group_ok;
	logic                   fields_ok;
	logic                   hit;

	assign wr_idx      = SLOT_W'(item.slot);
	assign wr_ok       = cmd.write && ({4'b0, item.slot} < 9'(RULE_SLOTS));
	assign status.last = (addr_q == SLOT_W'(RULE_SLOTS - 1));
	assign result      = result_q;

	always_ff @(posedge clk) begin
		if (wr_ok) begin
			rule_mem[wr_idx] <= '{
				drop_action: item.drop_action,
				rule_group:  item.rule_group,
				wild_flags:  item.wild_flags,
				direction:   item.direction,
				protocol:    item.protocol,
				src_addr:    item.src_addr,
				dst_addr:    item.dst_addr,
				sport:       item.sport,
				dst_port:    item.dst_port
			};
		end
		if (cmd.step) begin
			rule_s1 <= rule_mem[addr_q];
		end
		if (cmd.capture) begin
			pkt_q <= item;
		end
		slot_s1 <= addr_q;
		if (cmd.load_out) begin
			result_q.drop      <= best_hit_q;
			result_q.hit_slot  <= 5'(best_slot_q);
			result_q.hit_group <= best_grp_q;
		end
	end

	always_comb begin
		proto_ok = rule_s1.wild_flags[WILD_PROTO] ||
			(((rule_s1.protocol == PROTO_TCP) || (rule_s1.protocol == PROTO_UDP)) &&
			(rule_s1.protocol == pkt_q.protocol));
		group_ok = (rule_s1.rule_group == 4'd0) ||
			((rule_s1.rule_group <= 4'(NUM_GROUPS)) &&
			group_mask[3'(rule_s1.rule_group - 4'd1)]);
		fields_ok = (rule_s1.wild_flags[WILD_DIR] || (rule_s1.direction == pkt_q.direction)) &&
			(rule_s1.wild_flags[WILD_SADDR] || (rule_s1.src_addr == pkt_q.src_addr)) &&
			(rule_s1.wild_flags[WILD_DADDR] || (rule_s1.dst_addr == pkt_q.dst_addr)) &&
			(rule_s1.wild_flags[WILD_SPORT] || (rule_s1.sport == pkt_q.sport)) &&
			(rule_s1.wild_flags[WILD_DPORT] || (rule_s1.dst_port == pkt_q.dst_port));
		hit = vld_s1 && filter_enable && rule_s1.drop_action && group_ok &&
			proto_ok && fields_ok;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q     <= '0;
			vld_s1      <= 1'b0;
			addr_q      <= '0;
			best_hit_q  <= 1'b0;
			best_slot_q <= '0;
			best_grp_q  <= '0;
		end else begin
			if (wr_ok) begin
				valid_q[wr_idx] <= 1'b1;
			end
			vld_s1 <= cmd.step && valid_q[addr_q];
			if (cmd.capture) begin
				addr_q      <= '0;
				best_hit_q  <= 1'b0;
				best_slot_q <= '0;
				best_grp_q  <= '0;
			end else begin
				if (cmd.step) begin
					addr_q <= addr_q + SLOT_W'(1);
				end
				// Slots ascend, so a later hit wins if its group is equal or higher.
				if (hit && (!best_hit_q || (rule_s1.rule_group >= best_grp_q))) begin
					best_hit_q  <= 1'b1;
					best_slot_q <= slot_s1;
					best_grp_q  <= rule_s1.rule_group;
				end
			end
		end
	end

endmodule

// ===== tb/packet_rule_classifier_checker.sv =====
// Checker for the packet rule classifier. It watches the item, result and register
// ports, keeps its own copy of the rule table, predicts each verdict and compares it.
// Depends on prc_pkg.
module packet_rule_classifier_checker #(
	parameter int RULE_SLOTS = 32,
	parameter int NUM_GROUPS = 8
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         item_valid,
	input  logic                         item_stall,
	input  prc_pkg::in_item_t            item,
	input  logic                         result_valid,
	input  logic                         result_stall,
	input  prc_pkg::out_item_t           result,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [prc_pkg::PADDR_W-1:0]  paddr,
	input  logic [31:0]                  pwdata,
	input  logic                         pready,
	output int                           fail_count,
	output int                           pending
);
	import prc_pkg::*;

	rule_t      rules [RULE_SLOTS];
	logic       filter_on;
	logic [7:0] group_mask;
	out_item_t  pending_verdicts [$];
	out_item_t  want;

	function automatic logic rule_hit(rule_t r, in_item_t p);
		if (!r.drop_action)
			return 1'b0;
		if (!r.wild_flags[WILD_PROTO] && !((r.protocol == PROTO_TCP ||
			r.protocol == PROTO_UDP) && r.protocol == p.protocol))
			return 1'b0;
		if (!r.wild_flags[WILD_DIR] && r.direction != p.direction)
			return 1'b0;
		if (!r.wild_flags[WILD_SADDR] && r.src_addr != p.src_addr)
			return 1'b0;
		if (!r.wild_flags[WILD_DADDR] && r.dst_addr != p.dst_addr)
			return 1'b0;
		if (!r.wild_flags[WILD_SPORT] && r.sport != p.sport)
			return 1'b0;
		if (!r.wild_flags[WILD_DPORT] && r.dst_port != p.dst_port)
			return 1'b0;
		return 1'b1;
	endfunction

	// Standalone rules are scanned first, then each enabled group in turn; the last hit wins.
	function automatic out_item_t predict_verdict(in_item_t p);
		out_item_t v;
		v = '0;
		if (filter_on) begin
			for (int g = 0; g <= NUM_GROUPS; g++) begin
				if (g == 0 || group_mask[g-1]) begin
					for (int s = 0; s < RULE_SLOTS; s++) begin
						if (rules[s].rule_group == g && rule_hit(rules[s], p)) begin
							v.drop      = 1'b1;
							v.hit_slot  = 5'(s);
							v.hit_group = 4'(g);
						end
					end
				end
			end
		end
		return v;
	endfunction

	function void check_field(string name, int unsigned want_v, int unsigned got_v);
		if (want_v != got_v) begin
			fail_count++;
			$display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want_v, got_v);
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			foreach (rules[i])
				rules[i] = '0;
			filter_on  = 1'b0;
			group_mask = '0;
			pending_verdicts.delete();
			fail_count = 0;
			pending    = 0;
		end else begin
			if (result_valid && !result_stall) begin
				if (pending_verdicts.size() == 0) begin
					fail_count++;
					$display("%0t: result with no verdict waiting, expected none, got %h",
						$time, result);
				end else begin
					want = pending_verdicts.pop_front();
					check_field("drop", want.drop, result.drop);
					check_field("hit_slot", want.hit_slot, result.hit_slot);
					check_field("hit_group", want.hit_group, result.hit_group);
				end
			end
			if (item_valid && !item_stall) begin
				if (item.kind == KIND_CLASSIFY) begin
					pending_verdicts.push_back(predict_verdict(item));
				end else if (item.slot < RULE_SLOTS) begin
					rules[item.slot] = '{
						drop_action: item.drop_action,
						rule_group:  item.rule_group,
						wild_flags:  item.wild_flags,
						direction:   item.direction,
						protocol:    item.protocol,
						src_addr:    item.src_addr,
						dst_addr:    item.dst_addr,
						sport:       item.sport,
						dst_port:    item.dst_port
					};
				end
			end
			if (psel && penable && pwrite && pready) begin
				if (paddr == {REG_FILTER_ENABLE, 2'b00})
					filter_on = pwdata[0];
				else if (paddr == {REG_GROUP_MASK, 2'b00})
					group_mask = pwdata[7:0];
			end
			pending = pending_verdicts.size();
		end
	end

endmodule

// ===== tb/packet_rule_classifier_test.sv =====
// Top of the packet rule classifier test: clock, reset, register writes, directed and
// random items with random idling and result stalls, and the verdict. Depends on prc_pkg,
// the classifier and packet_rule_classifier_checker.
module packet_rule_classifier_test;
	import prc_pkg::*;

	localparam int RULE_SLOTS    = 32;
	localparam int NUM_GROUPS    = 8;
	localparam int CYCLE_LIMIT   = 1000000;
	localparam int DRAIN_CYCLES  = RULE_SLOTS + 8;
	localparam int RANDOM_PHASES = 8;
	localparam int PHASE_ITEMS   = 150;

	typedef enum int {PACE_FREE, PACE_SENDER, PACE_RECEIVER, PACE_BOTH} pace_t;

	logic                clk          = 1'b0;
	logic                arst_n       = 1'b0;
	logic                item_valid   = 1'b0;
	logic                item_stall;
	in_item_t            item         = '0;
	logic                result_valid;
	logic                result_stall = 1'b0;
	out_item_t           result;
	logic                psel         = 1'b0;
	logic                penable      = 1'b0;
	logic                pwrite       = 1'b0;
	logic [PADDR_W-1:0]  paddr        = '0;
	logic [31:0]         pwdata       = '0;
	logic [31:0]         prdata;
	logic                pready;
	int                  fail_count;
	int                  pending;
	int                  idle_pct     = 0;
	int                  stall_pct    = 0;
	int                  cycles       = 0;
	logic [31:0]         addr_pool [4];
	logic [15:0]         port_pool [4];

	packet_rule_classifier #(
		.RULE_SLOTS(RULE_SLOTS),
		.NUM_GROUPS(NUM_GROUPS)
	) u_top (.*);

	packet_rule_classifier_checker #(
		.RULE_SLOTS(RULE_SLOTS),
		.NUM_GROUPS(NUM_GROUPS)
	) u_checker (.*);

	initial begin
		forever #5 clk = ~clk;
	end

	always @(negedge clk) begin
		result_stall <= ($urandom_range(0, 99) < stall_pct);
	end

	initial begin
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("Some tests failed");
		$finish;
	end

	function automatic logic [31:0] pick_addr();
		if ($urandom_range(0, 7) == 0)
			return $urandom;
		return addr_pool[$urandom_range(0, 3)];
	endfunction

	function automatic logic [15:0] pick_port();
		if ($urandom_range(0, 7) == 0)
			return 16'($urandom);
		return port_pool[$urandom_range(0, 3)];
	endfunction

	function automatic logic [7:0] pick_proto();
		case ($urandom_range(0, 7))
			0, 1, 2: return PROTO_TCP;
			3, 4, 5: return PROTO_UDP;
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	function automatic in_item_t rand_item();
		in_item_t it;
		it.kind        = ($urandom_range(0, 9) < 4) ? KIND_LOAD : KIND_CLASSIFY;
		it.slot        = 5'($urandom_range(0, 31));
		it.rule_group  = ($urandom_range(0, 11) == 0) ? 4'($urandom_range(9, 15)) :
			4'($urandom_range(0, 8));
		it.drop_action = ($urandom_range(0, 4) != 0);
		it.protocol    = pick_proto();
		it.direction   = 1'($urandom_range(0, 1));
		it.wild_flags  = 6'($urandom_range(0, 63));
		it.src_addr    = pick_addr();
		it.dst_addr    = pick_addr();
		it.sport       = pick_port();
		it.dst_port    = pick_port();
		return it;
	endfunction

	function automatic in_item_t mk_rule(int slot, int grp, logic act, logic [7:0] proto,
		logic dir, logic [5:0] wild, logic [31:0] sa, logic [31:0] da,
		logic [15:0] sp, logic [15:0] dp);
		in_item_t it;
		it = '{kind: KIND_LOAD, slot: 5'(slot), rule_group: 4'(grp), drop_action: act,
			protocol: proto, direction: dir, wild_flags: wild, src_addr: sa,
			dst_addr: da, sport: sp, dst_port: dp};
		return it;
	endfunction

	function automatic in_item_t mk_pkt(logic [7:0] proto, logic dir, logic [31:0] sa,
		logic [31:0] da, logic [15:0] sp, logic [15:0] dp);
		in_item_t it;
		it = '{kind: KIND_CLASSIFY, slot: '0, rule_group: '0, drop_action: 1'b0,
			protocol: proto, direction: dir, wild_flags: '0, src_addr: sa,
			dst_addr: da, sport: sp, dst_port: dp};
		return it;
	endfunction

	task automatic set_pace(pace_t mode);
		case (mode)
			PACE_FREE:     begin idle_pct = 0;  stall_pct = 0;  end
			PACE_SENDER:   begin idle_pct = 57; stall_pct = 0;  end
			PACE_RECEIVER: begin idle_pct = 0;  stall_pct = 57; end
			PACE_BOTH:     begin idle_pct = 17; stall_pct = 17; end
		endcase
	endtask

	// Called and returns at a falling edge; valid stays high for the next item.
	task automatic send_item(in_item_t it);
		while ($urandom_range(0, 99) < idle_pct) begin
			item_valid <= 1'b0;
			@(negedge clk);
		end
		item_valid <= 1'b1;
		item       <= it;
		do
			@(posedge clk);
		while (item_stall);
		@(negedge clk);
	endtask

	// Load items add no pending verdict in the checker, so the wait ends with a drain.
	task automatic wait_idle();
		item_valid <= 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(logic idx, logic [31:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= value;
		@(negedge clk);
		penable <= 1'b1;
		do
			@(posedge clk);
		while (!pready);
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	task automatic configure(logic en, logic [7:0] mask);
		wait_idle();
		write_reg(REG_FILTER_ENABLE, {31'b0, en});
		@(negedge clk);
		write_reg(REG_GROUP_MASK, {24'b0, mask});
		@(negedge clk);
	endtask

	initial begin
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		set_pace(PACE_FREE);

		// Filtering is off after reset, so even a catch-all drop rule lets packets through.
		send_item(mk_rule(5, 0, 1'b1, 8'd0, 1'b0, 6'h3F, '0, '0, '0, '0));
		send_item(mk_pkt(PROTO_TCP, 1'b1, 32'h0a000001, 32'h0a000002, 16'd80, 16'd443));

		configure(1'b1, 8'hFF);
		send_item(mk_pkt(8'hFF, 1'b1, '1, '1, '1, '1));
		send_item(mk_rule(5, 0, 1'b0, 8'd0, 1'b0, 6'h3F, '0, '0, '0, '0));
		send_item(mk_pkt(8'h00, 1'b0, '0, '0, '0, '0));
		send_item(mk_rule(0, 0, 1'b1, PROTO_TCP, 1'b0, 6'h00, '0, '0, '0, '0));
		send_item(mk_pkt(PROTO_TCP, 1'b0, '0, '0, '0, '0));
		send_item(mk_pkt(PROTO_UDP, 1'b0, '0, '0, '0, '0));
		send_item(mk_rule(31, 0, 1'b1, PROTO_UDP, 1'b1, 6'h00, '1, '1, '1, '1));
		send_item(mk_pkt(PROTO_UDP, 1'b1, '1, '1, '1, '1));
		// An unknown rule protocol only matches through its wildcard.
		send_item(mk_rule(3, 0, 1'b1, 8'd50, 1'b0, 6'h3E, '0, '0, '0, '0));
		send_item(mk_pkt(8'd50, 1'b1, 32'h12345678, 32'h9abcdef0, 16'd7, 16'd9));
		send_item(mk_rule(4, 0, 1'b1, 8'd50, 1'b0, 6'h03, 32'd1, 32'd2, 16'd3, 16'd4));
		send_item(mk_pkt(8'd99, 1'b1, 32'd1, 32'd2, 16'd3, 16'd4));
		// Groups above the group count are stored but never match.
		send_item(mk_rule(10, 9, 1'b1, 8'd0, 1'b0, 6'h3F, '0, '0, '0, '0));
		send_item(mk_rule(11, 15, 1'b1, 8'd0, 1'b0, 6'h3F, '0, '0, '0, '0));
		send_item(mk_pkt(8'd1, 1'b0, 32'h01020304, 32'h05060708, 16'd1, 16'd2));
		send_item(mk_rule(2, 8, 1'b1, PROTO_TCP, 1'b0, 6'h3E, '0, '0, '0, '0));
		send_item(mk_rule(20, 3, 1'b1, PROTO_TCP, 1'b0, 6'h3E, '0, '0, '0, '0));
		send_item(mk_pkt(PROTO_TCP, 1'b1, 32'hc0a80001, 32'hc0a80002, 16'd1234, 16'd22));

		configure(1'b1, 8'h04);
		send_item(mk_pkt(PROTO_TCP, 1'b1, 32'hc0a80001, 32'hc0a80002, 16'd1234, 16'd22));

		for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
			case (ph)
				0:       configure(1'b1, 8'hFF);
				1:       configure(1'b1, 8'h00);
				3:       configure(1'b0, 8'($urandom));
				7:       configure(1'b1, 8'hAA);
				default: configure(1'b1, 8'($urandom));
			endcase
			set_pace(pace_t'(ph % 4));
			addr_pool[0] = '0;
			addr_pool[1] = '1;
			addr_pool[2] = $urandom;
			addr_pool[3] = $urandom;
			port_pool[0] = '0;
			port_pool[1] = '1;
			port_pool[2] = 16'($urandom);
			port_pool[3] = 16'($urandom);
			repeat (PHASE_ITEMS) send_item(rand_item());
		end

		wait_idle();
		if (fail_count == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
